>>> rtl/core/source_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// source_tokenizer_defines
// Assertion macros used by the tokenizer top level.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define STOK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define STOK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Types, token kinds and helper functions for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

   localparam int OFFSET_BITS_DEF     = 32;
   localparam int KEYWORD_MAX_LEN_DEF = 8;
   localparam int MAX_RESULTS         = 3;
   localparam int FIFO_DEPTH          = 4;

   localparam logic [5:0] KIND_THINARROW = 6'd8;
   localparam logic [5:0] KIND_FATARROW  = 6'd9;
   localparam logic [5:0] KIND_MINUS     = 6'd15;
   localparam logic [5:0] KIND_EQ        = 6'd19;
   localparam logic [5:0] KIND_KW0       = 6'd20;
   localparam logic [5:0] KIND_IDENT     = 6'd31;
   localparam logic [5:0] KIND_LIT       = 6'd32;
   localparam logic [5:0] KIND_ERR       = 6'd33;
   localparam logic [5:0] KIND_EOF       = 6'd34;
   localparam int         NUM_KEYWORDS   = 11;

   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_BIN = 2'd1;
   localparam logic [1:0] BASE_OCT = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [63:0] int_value;
      logic        is_float;
      logic [31:0] begin_offset;
      logic [31:0] end_offset;
      logic        run_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                    count;
      rsp_type [MAX_RESULTS-1:0]     items;
   } push_type;

   // keyword text, first character in the low byte
   function automatic logic [63:0] kw_text(input int idx);
      logic [63:0] t;
      case (idx)
         0:       t = {"e", "s", "r", "e", "v", "i", "n", "U"};
         1:       t = {32'h0, "e", "p", "y", "T"};
         2:       t = {32'h0, "t", "n", "I", "U"};
         3:       t = {40'h0, "t", "a", "N"};
         4:       t = {40'h0, "t", "n", "I"};
         5:       t = {24'h0, "t", "a", "o", "l", "F"};
         6:       t = {48'h0, "n", "i"};
         7:       t = {40'h0, "t", "e", "l"};
         8:       t = {16'h0, "c", "e", "r", "t", "e", "l"};
         9:       t = {32'h0, "e", "s", "a", "c"};
         10:      t = {48'h0, "f", "o"};
         default: t = 64'h0;
      endcase
      return t;
   endfunction

   function automatic logic [4:0] kw_len(input int idx);
      logic [4:0] l;
      case (idx)
         0:       l = 5'd8;
         1:       l = 5'd4;
         2:       l = 5'd4;
         3:       l = 5'd3;
         4:       l = 5'd3;
         5:       l = 5'd5;
         6:       l = 5'd2;
         7:       l = 5'd3;
         8:       l = 5'd6;
         9:       l = 5'd4;
         10:      l = 5'd2;
         default: l = 5'd31;
      endcase
      return l;
   endfunction

   // len is 31 when the identifier is too long to be a keyword
   function automatic logic [5:0] ident_kind(input logic [63:0] bytes,
                                             input logic [4:0] len);
      logic [5:0] k;
      k = KIND_IDENT;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (len == kw_len(i) && bytes == kw_text(i)) begin
            k = KIND_KW0 + 6'(i);
         end
      end
      return k;
   endfunction

   // {valid, value}
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
      logic [4:0] r;
      r = 5'd0;
      case (base)
         BASE_BIN: if (c inside {"0", "1"}) r = {1'b1, 4'(c - "0")};
         BASE_OCT: if (c inside {["0":"7"]}) r = {1'b1, 4'(c - "0")};
         default: begin
            if (c inside {["0":"9"]}) r = {1'b1, 4'(c - "0")};
            else if (base == BASE_HEX && (c inside {["a":"f"]})) r = {1'b1, 4'(c - "a" + 8'd10)};
            else if (base == BASE_HEX && (c inside {["A":"F"]})) r = {1'b1, 4'(c - "A" + 8'd10)};
         end
      endcase
      return r;
   endfunction

   // {overflow, value*base + d}
   function automatic logic [64:0] accumulate(input logic [63:0] v, input logic [1:0] base,
                                              input logic [3:0] d);
      logic [67:0] p;
      case (base)
         BASE_BIN: p = {4'h0, v} << 1;
         BASE_OCT: p = {4'h0, v} << 3;
         BASE_HEX: p = {4'h0, v} << 4;
         default:  p = ({4'h0, v} << 3) + ({4'h0, v} << 1);
      endcase
      p = p + {64'h0, d};
      return {|p[67:64], p[63:0]};
   endfunction

endpackage

>>> rtl/core/stok_core.sv
// ----------------------------------------------------------------------------
// stok_core
// Lexer state and the single-pass token logic for one request.
// ----------------------------------------------------------------------------
module stok_core
   import stok_pkg::*;
#(
   parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step_en,
   input  req_type  req,
   output push_type push
);

   localparam int LEN_BITS = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int ID_BITS  = 8 * KEYWORD_MAX_LEN;

   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_COMMENT = 4'd1;
   localparam logic [3:0] M_IDENT   = 4'd2;
   localparam logic [3:0] M_MINUS   = 4'd3;
   localparam logic [3:0] M_EQ      = 4'd4;
   localparam logic [3:0] M_ZERO    = 4'd5;
   localparam logic [3:0] M_INT     = 4'd6;
   localparam logic [3:0] M_FRAC    = 4'd7;
   localparam logic [3:0] M_EXPSIGN = 4'd8;
   localparam logic [3:0] M_EXPDIG  = 4'd9;

   logic [3:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [ID_BITS-1:0]     idb_ff, idb_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [63:0]            val_ff, val_in;
   logic [1:0]             base_ff, base_in;
   logic                   ovf_ff, ovf_in;
   logic                   flt_ff, flt_in;

   logic [7:0]             c;
   logic                   ext;
   logic [4:0]             dig;
   logic [64:0]            acc;
   logic [1:0]             n;
   logic [OFFSET_BITS-1:0] off_next;
   logic [5:0]             sym_kind;
   logic                   is_sym;
   push_type               push_v;

   function automatic logic [31:0] out_off(input logic [OFFSET_BITS-1:0] o);
      logic [OFFSET_BITS+31:0] w;
      w = {32'h0, o};
      return w[31:0];
   endfunction

   function automatic rsp_type mk(input logic [5:0] kind, input logic [63:0] v,
                                  input logic flt, input logic [OFFSET_BITS-1:0] b,
                                  input logic [OFFSET_BITS-1:0] e);
      rsp_type r;
      r.token_kind   = kind;
      r.int_value    = v;
      r.is_float     = flt;
      r.begin_offset = out_off(b);
      r.end_offset   = out_off(e);
      r.run_end      = 1'b0;
      return r;
   endfunction

   function automatic logic [5:0] cur_ident_kind(input logic [ID_BITS-1:0] b,
                                                 input logic [LEN_BITS-1:0] l);
      logic [4:0] l5;
      if (l > LEN_BITS'(KEYWORD_MAX_LEN) || l > LEN_BITS'(8)) l5 = 5'd31;
      else l5 = 5'(l);
      return ident_kind(b[63:0], l5);
   endfunction

   always_comb begin
      sym_kind = 6'd0;
      is_sym   = 1'b1;
      case (c)
         "(":     sym_kind = 6'd0;
         ")":     sym_kind = 6'd1;
         "{":     sym_kind = 6'd2;
         "}":     sym_kind = 6'd3;
         "[":     sym_kind = 6'd4;
         "]":     sym_kind = 6'd5;
         ".":     sym_kind = 6'd10;
         ":":     sym_kind = 6'd11;
         ";":     sym_kind = 6'd12;
         ",":     sym_kind = 6'd13;
         "\\":    sym_kind = 6'd18;
         "|":     sym_kind = 6'd17;
         default: is_sym = 1'b0;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      off_in   = off_ff;
      idb_in   = idb_ff;
      len_in   = len_ff;
      val_in   = val_ff;
      base_in  = base_ff;
      ovf_in   = ovf_ff;
      flt_in   = flt_ff;
      push_v   = '0;
      n        = 2'd0;
      ext      = 1'b0;
      c        = req.data_byte;
      dig      = digit_of(c, base_ff);
      acc      = '0;
      off_next = off_ff + OFFSET_BITS'(1);

      if (req.byte_present) begin
         case (mode_ff)
            M_COMMENT: begin
               ext = 1'b1;
               if (c == 8'd10) mode_in = M_IDLE;
            end
            M_IDENT: begin
               if (c == "_" || (c inside {["a":"z"], ["A":"Z"], ["0":"9"]})) begin
                  for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                     if (len_ff == LEN_BITS'(i)) idb_in[8*i +: 8] = c;
                  end
                  if (len_ff <= LEN_BITS'(KEYWORD_MAX_LEN)) len_in = len_ff + LEN_BITS'(1);
                  ext = 1'b1;
               end
            end
            M_MINUS, M_EQ: begin
               if (c == ">") begin
                  push_v.items[n] = mk((mode_ff == M_MINUS) ? KIND_THINARROW : KIND_FATARROW,
                                       64'h0, 1'b0, start_ff, off_next);
                  n       = n + 2'd1;
                  mode_in = M_IDLE;
                  ext     = 1'b1;
               end
            end
            M_ZERO: begin
               if (c == "b" || c == "B") begin
                  base_in = BASE_BIN;
                  mode_in = M_INT;
                  ext     = 1'b1;
               end else if (c == "x" || c == "X") begin
                  base_in = BASE_HEX;
                  mode_in = M_INT;
                  ext     = 1'b1;
               end else begin
                  base_in = BASE_OCT;
                  if (c inside {["0":"7"]}) begin
                     acc     = accumulate(val_ff, BASE_OCT, 4'(c - "0"));
                     val_in  = acc[63:0];
                     ovf_in  = ovf_ff | acc[64];
                     mode_in = M_INT;
                     ext     = 1'b1;
                  end
               end
            end
            M_INT: begin
               if (dig[4]) begin
                  acc    = accumulate(val_ff, base_ff, dig[3:0]);
                  val_in = acc[63:0];
                  ovf_in = ovf_ff | acc[64];
                  ext    = 1'b1;
               end else if (base_ff == BASE_BIN || base_ff == BASE_OCT) begin
                  ext = 1'b0;
               end else if (c == ".") begin
                  flt_in  = 1'b1;
                  mode_in = M_FRAC;
                  ext     = 1'b1;
               end else if ((base_ff == BASE_HEX && (c == "p" || c == "P")) ||
                            (base_ff != BASE_HEX && (c == "e" || c == "E"))) begin
                  flt_in  = 1'b1;
                  mode_in = M_EXPSIGN;
                  ext     = 1'b1;
               end
            end
            M_FRAC: begin
               if (dig[4]) begin
                  ext = 1'b1;
               end else if ((base_ff == BASE_HEX && (c == "p" || c == "P")) ||
                            (base_ff != BASE_HEX && (c == "e" || c == "E"))) begin
                  mode_in = M_EXPSIGN;
                  ext     = 1'b1;
               end
            end
            M_EXPSIGN: begin
               if (c == "+" || c == "-" || (c inside {["0":"9"]})) begin
                  mode_in = M_EXPDIG;
                  ext     = 1'b1;
               end
            end
            M_EXPDIG: ext = c inside {["0":"9"]};
            default:  ext = 1'b0;
         endcase

         if (!ext) begin
            // flush the pending token, ending at the current offset
            case (mode_ff)
               M_IDENT: begin
                  push_v.items[n] = mk(cur_ident_kind(idb_ff, len_ff), 64'h0, 1'b0,
                                       start_ff, off_ff);
                  n = n + 2'd1;
               end
               M_MINUS: begin
                  push_v.items[n] = mk(KIND_MINUS, 64'h0, 1'b0, start_ff, off_ff);
                  n = n + 2'd1;
               end
               M_EQ: begin
                  push_v.items[n] = mk(KIND_EQ, 64'h0, 1'b0, start_ff, off_ff);
                  n = n + 2'd1;
               end
               M_ZERO: begin
                  push_v.items[n] = mk(KIND_LIT, 64'h0, 1'b0, start_ff, off_ff);
                  n = n + 2'd1;
               end
               M_INT, M_FRAC, M_EXPSIGN, M_EXPDIG: begin
                  if (flt_ff) push_v.items[n] = mk(KIND_LIT, 64'h0, 1'b1, start_ff, off_ff);
                  else if (ovf_ff) push_v.items[n] = mk(KIND_ERR, 64'h0, 1'b0, start_ff, off_ff);
                  else push_v.items[n] = mk(KIND_LIT, val_ff, 1'b0, start_ff, off_ff);
                  n = n + 2'd1;
               end
               default: ;
            endcase
            mode_in = M_IDLE;

            // start a new token from idle
            if (c == 8'd32 || (c inside {[8'd9:8'd13]})) begin
               mode_in = M_IDLE;
            end else if (is_sym) begin
               push_v.items[n] = mk(sym_kind, 64'h0, 1'b0, off_ff, off_next);
               n = n + 2'd1;
            end else begin
               start_in = off_ff;
               val_in   = 64'h0;
               base_in  = BASE_DEC;
               ovf_in   = 1'b0;
               flt_in   = 1'b0;
               if (c == "-") mode_in = M_MINUS;
               else if (c == "=") mode_in = M_EQ;
               else if (c == "#") mode_in = M_COMMENT;
               else if (c == "_" || (c inside {["a":"z"], ["A":"Z"]})) begin
                  idb_in         = '0;
                  idb_in[7:0]    = c;
                  len_in         = LEN_BITS'(1);
                  mode_in        = M_IDENT;
               end else if (c == "0") mode_in = M_ZERO;
               else if (c inside {["1":"9"]}) begin
                  val_in  = {60'h0, 4'(c - "0")};
                  mode_in = M_INT;
               end else begin
                  push_v.items[n] = mk(KIND_ERR, 64'h0, 1'b0, off_ff, off_next);
                  n = n + 2'd1;
               end
            end
         end
         off_in = off_next;
      end

      if (req.end_of_input) begin
         case (mode_in)
            M_IDENT: begin
               push_v.items[n] = mk(cur_ident_kind(idb_in, len_in), 64'h0, 1'b0,
                                    start_in, off_in);
               n = n + 2'd1;
            end
            M_MINUS: begin
               push_v.items[n] = mk(KIND_MINUS, 64'h0, 1'b0, start_in, off_in);
               n = n + 2'd1;
            end
            M_EQ: begin
               push_v.items[n] = mk(KIND_EQ, 64'h0, 1'b0, start_in, off_in);
               n = n + 2'd1;
            end
            M_ZERO: begin
               push_v.items[n] = mk(KIND_LIT, 64'h0, 1'b0, start_in, off_in);
               n = n + 2'd1;
            end
            M_INT, M_FRAC, M_EXPSIGN, M_EXPDIG: begin
               if (flt_in) push_v.items[n] = mk(KIND_LIT, 64'h0, 1'b1, start_in, off_in);
               else if (ovf_in) push_v.items[n] = mk(KIND_ERR, 64'h0, 1'b0, start_in, off_in);
               else push_v.items[n] = mk(KIND_LIT, val_in, 1'b0, start_in, off_in);
               n = n + 2'd1;
            end
            default: ;
         endcase
         push_v.items[n] = mk(KIND_EOF, 64'h0, 1'b0, off_in, off_in);
         n = n + 2'd1;
         // new text starts from reset state
         mode_in  = M_IDLE;
         start_in = '0;
         off_in   = '0;
         idb_in   = '0;
         len_in   = '0;
         val_in   = 64'h0;
         base_in  = BASE_DEC;
         ovf_in   = 1'b0;
         flt_in   = 1'b0;
      end

      if (n != 2'd0) push_v.items[n - 2'd1].run_end = 1'b1;
      push_v.count = n;
      if (!step_en) push_v.count = 2'd0;
   end

   assign push = push_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         start_ff <= '0;
         off_ff   <= '0;
         idb_ff   <= '0;
         len_ff   <= '0;
         val_ff   <= 64'h0;
         base_ff  <= BASE_DEC;
         ovf_ff   <= 1'b0;
         flt_ff   <= 1'b0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         off_ff   <= off_in;
         idb_ff   <= idb_in;
         len_ff   <= len_in;
         val_ff   <= val_in;
         base_ff  <= base_in;
         ovf_ff   <= ovf_in;
         flt_ff   <= flt_in;
      end
   end

endmodule

>>> rtl/core/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte per request, tokens out through a queue.
// ----------------------------------------------------------------------------
// Request channel (req_): one source byte per request, with byte_present
// and end_of_input flags. A request is taken when req_valid is high and
// req_stall is low. Each request yields zero to three tokens.
// Result channel (rsp_): one token per transfer, taken when rsp_valid is
// high and rsp_stall is low; run_end marks the last token of a request.
// A request's tokens are queued for rsp_ in the cycle after it is taken.
// One request per cycle is taken while the four-entry queue holds at most
// one token; a request with several tokens drains at one token per cycle
// while rsp_stall is low, so the queue sets the sustained rate. When the
// receiver stalls, the queue fills and req_stall rises once two or more
// tokens are waiting. Reset clears the queue and the lexer state; end of
// input flushes the pending token, sends EOF and restarts offsets.
// ----------------------------------------------------------------------------
`include "source_tokenizer_defines.svh"

module source_tokenizer
   import stok_pkg::*;
#(
   parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

   rsp_type               fifo_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in;
   logic [PTR_BITS-1:0]   rd_ff, rd_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  step_en;
   logic                  pop;
   push_type              push;

   assign req_stall = count_ff > CNT_BITS'(1);
   assign step_en   = req_valid & ~req_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = fifo_ff[rd_ff];
   assign pop       = rsp_valid & ~rsp_stall;

   stok_core #(
      .OFFSET_BITS     (OFFSET_BITS),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (req_data),
      .push    (push)
   );

   assign wr_in    = wr_ff + PTR_BITS'(push.count);
   assign rd_in    = rd_ff + PTR_BITS'(pop);
   assign count_in = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push.count) fifo_ff[wr_ff + PTR_BITS'(k)] <= push.items[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `STOK_ASSERT_NOW(a_queue_bound, 1'b1, count_ff <= CNT_BITS'(FIFO_DEPTH), "result queue overrun")
   `STOK_ASSERT_NEXT(a_eof_queued, step_en && req_data.end_of_input, count_ff != '0, "EOF token missing")
   `STOK_ASSERT_NEXT(a_hold_result, rsp_valid && rsp_stall, rsp_valid, "stalled token dropped")

endmodule

>>> tb/source_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_tokenizer_tb
// Feeds source bytes to the tokenizer, predicts each token in a local lexer
// model and compares every token leaving the result channel in order.
// ----------------------------------------------------------------------------
module source_tokenizer_tb;
   import stok_pkg::*;

   localparam int KW_MAX     = 8;
   localparam int MAX_CYCLES = 400000;

   typedef enum int {
      LX_IDLE, LX_COMMENT, LX_IDENT, LX_MINUS, LX_EQ, LX_ZERO, LX_INT, LX_FRAC,
      LX_EXPSIGN, LX_EXPDIG
   } lex_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   source_tokenizer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // lexer model state
   lex_mode_type mode;
   logic [31:0]  tok_start;
   logic [31:0]  offset;
   logic [7:0]   id_bytes [KW_MAX];
   int           id_len;
   logic [63:0]  lit_val;
   logic [1:0]   lit_base;
   logic         lit_ovf;
   logic         lit_flt;

   rsp_type     token_queue [$];
   rsp_type     step_tokens [$];
   int          mismatches;
   int          tokens_seen;
   int          reqs_sent;
   int          cycles;
   bit          rsp_idle_mode;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // value of a digit in the given base, or -1 if c is not a digit of it
   function automatic int digit_val(logic [7:0] c, logic [1:0] base);
      if (base == BASE_BIN) return (c == "0" || c == "1") ? c - "0" : -1;
      if (base == BASE_OCT) return (c >= "0" && c <= "7") ? c - "0" : -1;
      if (is_dig(c)) return c - "0";
      if (base == BASE_HEX) begin
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
      end
      return -1;
   endfunction

   function automatic bit is_exp(logic [7:0] c);
      if (lit_base == BASE_HEX) return c == "p" || c == "P";
      return c == "e" || c == "E";
   endfunction

   function automatic void push_token(logic [5:0] kind, logic [63:0] val, logic flt,
                                      logic [31:0] b, logic [31:0] e);
      rsp_type t;
      t.token_kind   = kind;
      t.int_value    = val;
      t.is_float     = flt;
      t.begin_offset = b;
      t.end_offset   = e;
      t.run_end      = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic logic [5:0] word_kind();
      string kws [11];
      string w;
      kws = '{"Universe", "Type", "UInt", "Nat", "Int", "Float", "in", "let",
              "letrec", "case", "of"};
      if (id_len > KW_MAX) return KIND_IDENT;
      w = "";
      for (int i = 0; i < id_len; i++) w = {w, string'(id_bytes[i])};
      for (int i = 0; i < 11; i++) if (kws[i] == w) return KIND_KW0 + 6'(i);
      return KIND_IDENT;
   endfunction

   function automatic void add_digit(int d);
      logic [67:0] p;
      int          b;
      b = lit_base == BASE_BIN ? 2 : lit_base == BASE_OCT ? 8 :
          lit_base == BASE_HEX ? 16 : 10;
      p = 68'(lit_val) * b + d;
      if (|p[67:64]) lit_ovf = 1'b1;
      lit_val = p[63:0];
   endfunction

   task automatic flush_pending();
      case (mode)
         LX_IDENT: push_token(word_kind(), 0, 0, tok_start, offset);
         LX_MINUS: push_token(KIND_MINUS, 0, 0, tok_start, offset);
         LX_EQ:    push_token(KIND_EQ, 0, 0, tok_start, offset);
         LX_ZERO:  push_token(KIND_LIT, 0, 0, tok_start, offset);
         LX_INT, LX_FRAC, LX_EXPSIGN, LX_EXPDIG: begin
            if (lit_flt) push_token(KIND_LIT, 0, 1, tok_start, offset);
            else if (lit_ovf) push_token(KIND_ERR, 0, 0, tok_start, offset);
            else push_token(KIND_LIT, lit_val, 0, tok_start, offset);
         end
         default: ;
      endcase
      mode = LX_IDLE;
   endtask

   function automatic bit try_extend(logic [7:0] c);
      int d;
      case (mode)
         LX_COMMENT: begin
            if (c == 8'h0a) mode = LX_IDLE;
            return 1;
         end
         LX_IDENT: begin
            if (c == "_" || is_alpha(c) || is_dig(c)) begin
               if (id_len < KW_MAX) id_bytes[id_len] = c;
               if (id_len <= KW_MAX) id_len++;
               return 1;
            end
            return 0;
         end
         LX_MINUS, LX_EQ: begin
            if (c != ">") return 0;
            push_token(mode == LX_MINUS ? KIND_THINARROW : KIND_FATARROW, 0, 0,
                       tok_start, offset + 1);
            mode = LX_IDLE;
            return 1;
         end
         LX_ZERO: begin
            if (c == "b" || c == "B") begin lit_base = BASE_BIN; mode = LX_INT; return 1; end
            if (c == "x" || c == "X") begin lit_base = BASE_HEX; mode = LX_INT; return 1; end
            lit_base = BASE_OCT;
            d = digit_val(c, BASE_OCT);
            if (d < 0) return 0;
            mode = LX_INT;
            add_digit(d);
            return 1;
         end
         LX_INT: begin
            d = digit_val(c, lit_base);
            if (d >= 0) begin add_digit(d); return 1; end
            if (lit_base == BASE_BIN || lit_base == BASE_OCT) return 0;
            if (c == ".") begin lit_flt = 1; mode = LX_FRAC; return 1; end
            if (is_exp(c)) begin lit_flt = 1; mode = LX_EXPSIGN; return 1; end
            return 0;
         end
         LX_FRAC: begin
            if (digit_val(c, lit_base) >= 0) return 1;
            if (is_exp(c)) begin mode = LX_EXPSIGN; return 1; end
            return 0;
         end
         LX_EXPSIGN: begin
            if (c == "+" || c == "-" || is_dig(c)) begin mode = LX_EXPDIG; return 1; end
            return 0;
         end
         LX_EXPDIG: return is_dig(c);
         default: return 0;
      endcase
   endfunction

   task automatic start_token(logic [7:0] c);
      logic [7:0] syms [12];
      logic [5:0] kinds [12];
      syms  = '{"(", ")", "{", "}", "[", "]", ".", ":", ";", ",", "\\", "|"};
      kinds = '{0, 1, 2, 3, 4, 5, 10, 11, 12, 13, 18, 17};
      if (c == " " || (c >= 9 && c <= 13)) return;
      for (int i = 0; i < 12; i++) begin
         if (syms[i] == c) begin
            push_token(kinds[i], 0, 0, offset, offset + 1);
            return;
         end
      end
      tok_start = offset;
      lit_val   = 0;
      lit_base  = BASE_DEC;
      lit_ovf   = 0;
      lit_flt   = 0;
      if (c == "-") mode = LX_MINUS;
      else if (c == "=") mode = LX_EQ;
      else if (c == "#") mode = LX_COMMENT;
      else if (c == "_" || is_alpha(c)) begin
         for (int i = 0; i < KW_MAX; i++) id_bytes[i] = 0;
         id_bytes[0] = c;
         id_len = 1;
         mode = LX_IDENT;
      end
      else if (c == "0") mode = LX_ZERO;
      else if (is_dig(c)) begin lit_val = c - "0"; mode = LX_INT; end
      else push_token(KIND_ERR, 0, 0, offset, offset + 1);
   endtask

   task automatic clear_lexer();
      mode = LX_IDLE; tok_start = 0; offset = 0;
      for (int i = 0; i < KW_MAX; i++) id_bytes[i] = 0;
      id_len = 0; lit_val = 0; lit_base = BASE_DEC; lit_ovf = 0; lit_flt = 0;
   endtask

   // compute the tokens one request causes and queue them
   task automatic predict_tokens(req_type r);
      step_tokens.delete();
      if (r.byte_present) begin
         if (!try_extend(r.data_byte)) begin
            flush_pending();
            start_token(r.data_byte);
         end
         offset = offset + 1;
      end
      if (r.end_of_input) begin
         flush_pending();
         push_token(KIND_EOF, 0, 0, offset, offset);
         clear_lexer();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].run_end = 1'b1;
      foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
   endtask

   task automatic send_req(logic [7:0] c, logic present, logic eoi);
      req_type r;
      int      gap;
      gap = gap_len();
      if (gap > 0) begin
         // drop valid for the idle gap
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.data_byte = c; r.byte_present = present; r.end_of_input = eoi;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(r);
      reqs_sent++;
   endtask

   task automatic send_text(string s, bit with_end);
      for (int i = 0; i < s.len(); i++)
         send_req(s[i], 1'b1, with_end && i == s.len() - 1);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (token_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %p", rsp_data);
         end else begin
            if (rsp_data !== token_queue[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token mismatch: expected %p actual %p", token_queue[0], rsp_data);
            end
            void'(token_queue.pop_front());
         end
      end
   end

   // receiver stall pattern
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = gap_len();
         if (rsp_idle_mode) n = 0;
         repeat (n) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_symbols();
      send_text("(){}[].:;,\\|", 1'b0);
      send_text("->=>-=<+*", 1'b1);
   endtask

   task automatic test_keywords();
      send_text("Universe Type UInt Nat Int Float in let letrec case of", 1'b0);
      send_text(" Universes abcdefghij_9#c\nq", 1'b1);
   endtask

   task automatic test_literals();
      send_text("0 0b101 0x 017 08 0.5 1e+3 0x1Fp3 7e", 1'b0);
      send_text(" 18446744073709551616", 1'b1);
   endtask

   task automatic test_edges();
      send_req(8'h00, 1'b0, 1'b0);
      send_req(8'h00, 1'b0, 1'b1);
      send_req(8'hff, 1'b1, 1'b0);
      send_req(8'h80, 1'b1, 1'b1);
      send_req("a", 1'b1, 1'b0);
      send_req("b", 1'b0, 1'b1);
   endtask

   task automatic test_random_text();
      string frags [16];
      string s;
      int    nfrag;
      frags = '{"let", "letrec", "x_1", "Nat", "0x3fA", "0b1101", "0755", "42",
                "3.14e-2", "->", "=>", "(", ")", "# c\n", " ", "of"};
      for (int k = 0; k < 2; k++) begin
         s = "";
         nfrag = $urandom_range(2, 5);
         for (int j = 0; j < nfrag; j++) begin
            s = {s, frags[$urandom_range(0, 15)]};
            if ($urandom_range(0, 2) != 0) s = {s, " "};
         end
         send_text(s, 1'b1);
      end
      // noise: any byte, any flag
      for (int k = 0; k < 12; k++)
         send_req(8'($urandom), $urandom_range(0, 7) != 0, $urandom_range(0, 11) == 0);
      send_req(8'h20, 1'b1, 1'b1);
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      mismatches = 0; tokens_seen = 0; reqs_sent = 0; cycles = 0;
      rsp_idle_mode = 1'b0;
      clear_lexer();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_symbols();
      test_keywords();
      rsp_idle_mode = 1'b1;
      test_literals();
      rsp_idle_mode = 1'b0;
      test_edges();
      test_random_text();
      req_valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d requests, checked %0d tokens: symbols, keywords, literals, noise",
               reqs_sent, tokens_seen);
      if (mismatches == 0 && token_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
